/* src/odgf_pkg.sv */
// Shared types, constants and the Bayer threshold table for the ordered-dither gradient fill.
package odgf_pkg;

	localparam int MAX_DIM   = 512;
	localparam int CFG_DIM_W = 10;
	localparam int DIM_W     = $clog2(MAX_DIM + 1);
	localparam int OFF_W     = $clog2(MAX_DIM);
	localparam int DEN_W     = $clog2(3 * MAX_DIM + 1);
	localparam int Q_W       = 6;
	localparam int CNT_W     = $clog2(Q_W);
	localparam int DENS_MAX  = 64;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X      = 3'd0,
		REG_ORIGIN_Y      = 3'd1,
		REG_REGION_WIDTH  = 3'd2,
		REG_REGION_HEIGHT = 3'd3,
		REG_START_DENSITY = 3'd4,
		REG_END_DENSITY   = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// row-major, index {row[2:0], col[2:0]}
	localparam logic [0:63][5:0] BAYER = {
		6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63,
		6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
		6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55,
		6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
		6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61,
		6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
		6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53,
		6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21
	};

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (int'(v) > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

	function automatic logic [6:0] clamp_density(input logic [6:0] v);
		return (v > 7'(DENS_MAX)) ? 7'(DENS_MAX) : v;
	endfunction

endpackage

/* src/ordered_dither_gradient_fill_top.sv */
// Top level of the ordered-dither gradient fill: scan state, control and output register.
//
// Usage:
//   Input channel (in_valid, in_stall, restart): each accepted word advances the
//   scan of the configured rectangle by one pixel in row-major order; restart=1
//   begins again at the top-left pixel. The scan wraps after the bottom-right one.
//   Output channel (out_valid, out_stall, pixel_x, pixel_y, paint_red, last_pixel):
//   one word per input word, in order.
//   Configuration: cfg_write with cfg_index and cfg_data writes one register;
//   write only while no word is in flight.
//   Sequence: the edge that accepts a word latches the coordinates and loads the
//   restoring divider; the divider then produces the 6-bit gradient position one
//   bit per cycle, and a final step scales the density and compares with the
//   Bayer threshold as the word enters the output register. The block then
//   returns to idle, and it accepts no new word until the last one has left
//   its final step.
//   A finished word waits in the output register while the receiver stalls;
//   the next word may be accepted meanwhile, but it cannot leave its final step
//   until the register frees.
//   Reset clears the scan to the top-left pixel, empties the output register
//   and returns the registers to origin 0, size 1x1, density 0 to 64.
module ordered_dither_gradient_fill_top import odgf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 restart,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [9:0]           pixel_x,
	output logic [9:0]           pixel_y,
	output logic                 paint_red,
	output logic                 last_pixel
);

	logic [8:0]           origin_x_q;
	logic [8:0]           origin_y_q;
	logic [CFG_DIM_W-1:0] width_q;
	logic [CFG_DIM_W-1:0] height_q;
	logic [6:0]           start_dens_q;
	logic [6:0]           end_dens_q;

	logic [OFF_W-1:0] col_q;
	logic [OFF_W-1:0] row_q;
	state_t           state_q;
	state_t           state_nx;
	logic             out_valid_q;

	logic [9:0]  px_s1;
	logic [9:0]  py_s1;
	logic        last_s1;
	logic [5:0]  thr_s1;

	logic [9:0]  px_q;
	logic [9:0]  py_q;
	logic        paint_q;
	logic        last_q;

	logic [DIM_W-1:0] w_c;
	logic [DIM_W-1:0] h_c;
	logic             in_acc;
	logic             wrap;
	logic [OFF_W-1:0] cur_col;
	logic [OFF_W-1:0] cur_row;
	logic             col_more;
	logic             row_more;
	logic             last_c;
	logic [DEN_W-1:0] dividend;
	logic [DEN_W-1:0] divisor;
	logic             load_out;

	logic [Q_W-1:0]     mix;
	div_stat_t          div_stat;
	logic signed [7:0]  s_d;
	logic signed [7:0]  e_d;
	logic signed [7:0]  diff;
	logic signed [14:0] prod;
	logic signed [14:0] prod_adj;
	logic signed [8:0]  dens;
	logic               paint_c;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			width_q      <= CFG_DIM_W'(1);
			height_q     <= CFG_DIM_W'(1);
			start_dens_q <= '0;
			end_dens_q   <= 7'(DENS_MAX);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ORIGIN_X:      origin_x_q   <= cfg_data[8:0];
				REG_ORIGIN_Y:      origin_y_q   <= cfg_data[8:0];
				REG_REGION_WIDTH:  width_q      <= cfg_data[CFG_DIM_W-1:0];
				REG_REGION_HEIGHT: height_q     <= cfg_data[CFG_DIM_W-1:0];
				REG_START_DENSITY: start_dens_q <= cfg_data[6:0];
				REG_END_DENSITY:   end_dens_q   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// ---------------- scan position ----------------
	assign w_c    = clamp_dim(width_q);
	assign h_c    = clamp_dim(height_q);
	assign in_acc = in_valid && !in_stall;

	// restart also when the region shrank under the current offsets
	assign wrap    = restart || (DIM_W'(col_q) >= w_c) || (DIM_W'(row_q) >= h_c);
	assign cur_col = wrap ? '0 : col_q;
	assign cur_row = wrap ? '0 : row_q;

	assign col_more = (DIM_W'(cur_col) + 1'b1) < w_c;
	assign row_more = (DIM_W'(cur_row) + 1'b1) < h_c;
	assign last_c   = (DIM_W'(cur_col) == w_c - 1'b1) && (DIM_W'(cur_row) == h_c - 1'b1);

	assign dividend = DEN_W'({cur_col, 1'b0}) + DEN_W'(cur_row);
	assign divisor  = DEN_W'({w_c, 1'b0}) + DEN_W'(h_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (col_more) begin
				col_q <= cur_col + 1'b1;
				row_q <= cur_row;
			end else begin
				col_q <= '0;
				row_q <= row_more ? cur_row + 1'b1 : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_s1   <= 10'(origin_x_q) + 10'(cur_col);
			py_s1   <= 10'(origin_y_q) + 10'(cur_row);
			last_s1 <= last_c;
			thr_s1  <= BAYER[{cur_row[2:0], cur_col[2:0]}];
		end
	end

	odgf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_acc),
		.dividend (dividend),
		.divisor  (divisor),
		.quotient (mix),
		.stat     (div_stat)
	);

	// ---------------- density and threshold ----------------
	assign s_d      = signed'({1'b0, clamp_density(start_dens_q)});
	assign e_d      = signed'({1'b0, clamp_density(end_dens_q)});
	assign diff     = e_d - s_d;
	assign prod     = 15'(diff) * signed'(15'(mix));
	// bias negative products so the shift truncates toward zero
	assign prod_adj = prod + ((prod < 0) ? 15'sd63 : 15'sd0);
	assign dens     = 9'(s_d) + 9'(prod_adj >>> 6);
	assign paint_c  = signed'(9'(thr_s1)) < dens;

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		in_stall = 1'b1;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_nx = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_nx = ST_FIN;
				end
			end
			ST_FIN: begin
				// hold until the output register is free
				load_out = !out_valid_q || !out_stall;
				if (load_out) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			px_q    <= px_s1;
			py_q    <= py_s1;
			paint_q <= paint_c;
			last_q  <= last_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_x    = px_q;
	assign pixel_y    = py_q;
	assign paint_red  = paint_q;
	assign last_pixel = last_q;

	// ---------------- assertions ----------------
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (div_stat.busy && state_q == ST_DIV))
		else $error("accepted word did not start the divider");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("output word appeared without a final step");

	a_busy_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> state_q == ST_DIV)
		else $error("divider running outside the divide state");

endmodule

/* src/odgf_div.sv */
// Restoring divider yielding one quotient bit per cycle for the gradient position.
module odgf_div import odgf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DEN_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic [Q_W-1:0]   quotient,
	output div_stat_t        stat
);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] r_q;
	logic [DEN_W-1:0] d_q;
	logic [Q_W-1:0]   q_q;
	logic [DEN_W:0]   r2;
	logic             ge;
	logic [DEN_W-1:0] r_next;
	logic             last_step;

	assign r2        = {r_q, 1'b0};
	assign ge        = r2 >= {1'b0, d_q};
	assign r_next    = ge ? DEN_W'(r2 - {1'b0, d_q}) : DEN_W'(r2);
	assign last_step = busy_q && (cnt_q == CNT_W'(Q_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last_step) begin
				busy_q <= 1'b0;
			end
		end
	end

	// dividend is below divisor, so the remainder always fits DEN_W bits
	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= dividend;
			d_q <= divisor;
		end else if (busy_q) begin
			r_q <= r_next;
			q_q <= {q_q[Q_W-2:0], ge};
		end
	end

	assign quotient  = q_q;
	assign stat.busy = busy_q;
	assign stat.done = last_step;

endmodule
